// ===== hdl/fls_pkg.sv =====
// Shared constants for the floor-of-linear-sum block.
// Used by the top level floor_of_linear_sum and its port checker; no dependencies.
`timescale 1ns / 1ps

package fls_pkg;

  // Width of the result field and of the padded result beat.
  localparam int TOTAL_W     = 60;
  localparam int OUT_TDATA_W = 64;

endpackage

// ===== hdl/floor_of_linear_sum.sv =====
// Top level of the floor-of-linear-sum block: sequencer plus one bit-serial mul/div unit.
// Depends on fls_pkg (result widths).
`timescale 1ns / 1ps

// Channel   Dir  Beat contents (lowest bits first)                        Handshake
// in_*      in   slope, offset, divisor, last_index (OPERAND_WIDTH each)   tvalid/tready
// out_*     out  total (60 bits), zero padded to 64                        tvalid/tready
//
// One request runs through setup states and then the reduction rounds;
// the number of rounds follows the Euclid steps on divisor and slope, at most
// about 1.5*OPERAND_WIDTH. The cost is set by the single shift/add unit, which
// retires one multiplier or quotient bit per cycle.
// rst_n is synchronous and active low; it clears the sequencer and the result valid.
// in_tready is high only while the block is idle. A finished result waits in the
// output register while the next request is accepted and worked on.

module floor_of_linear_sum #(
  parameter int OPERAND_WIDTH = 20
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // slope, offset, divisor, last_index from the lowest bit up, zero padded to bytes
  input  logic [((4*OPERAND_WIDTH+7)/8)*8-1:0]   in_tdata,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // total in the low 60 bits, upper bits zero
  output logic [fls_pkg::OUT_TDATA_W-1:0]        out_tdata
);

  localparam int W    = OPERAND_WIDTH;
  localparam int CW   = W + 1;
  localparam int PW   = 3 * W;
  localparam int LENW = $clog2(2 * W + 2);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CHK_A = 4'd1;
  localparam logic [3:0] ST_DIV_A = 4'd2;
  localparam logic [3:0] ST_TRI   = 4'd3;
  localparam logic [3:0] ST_TRIQ  = 4'd4;
  localparam logic [3:0] ST_CHK_B = 4'd5;
  localparam logic [3:0] ST_DIV_B = 4'd6;
  localparam logic [3:0] ST_BQ    = 4'd7;
  localparam logic [3:0] ST_TOP   = 4'd8;
  localparam logic [3:0] ST_TOP_M = 4'd9;
  localparam logic [3:0] ST_TOP_D = 4'd10;
  localparam logic [3:0] ST_FIN   = 4'd11;

  logic [3:0]                   state_r, state_nxt;
  logic [W-1:0]                 a_r, a_nxt;
  logic [W-1:0]                 b_r, b_nxt;
  logic [W-1:0]                 m_r, m_nxt;
  logic [CW-1:0]                cnt_r, cnt_nxt;
  logic [W-1:0]                 q_r, q_nxt;
  logic [fls_pkg::TOTAL_W-1:0]  sum_r, sum_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [fls_pkg::TOTAL_W-1:0]  out_data_r, out_data_nxt;

  // Shared unit registers
  logic                         u_busy_r, u_busy_nxt;
  logic                         u_div_r, u_div_nxt;
  logic [PW-1:0]                u_x_r, u_x_nxt;
  logic [CW-1:0]                u_y_r, u_y_nxt;
  logic [PW-1:0]                u_acc_r, u_acc_nxt;
  logic [LENW-1:0]              u_cnt_r, u_cnt_nxt;

  // Start request from the sequencer
  logic                         u_start;
  logic                         u_start_div;
  logic [LENW-1:0]              u_len;
  logic [PW-1:0]                u_x_init;
  logic [CW-1:0]                u_y_init;
  logic [PW-1:0]                u_acc_init;

  logic [PW-1:0]                opa, opb;
  logic                         op_sub;
  logic [PW:0]                  add_res;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = fls_pkg::OUT_TDATA_W'(out_data_r);

  // The one adder: accumulate in multiply mode, trial subtract in divide mode.
  always_comb begin
    if (u_div_r) begin
      opa    = {u_acc_r[PW-2:0], u_x_r[PW-1]};
      opb    = PW'(m_r);
      op_sub = 1'b1;
    end else begin
      opa    = u_acc_r;
      opb    = u_y_r[0] ? u_x_r : '0;
      op_sub = 1'b0;
    end
    add_res = {1'b0, opa} + {1'b0, opb ^ {PW{op_sub}}} + (PW+1)'(op_sub);
  end

  // Unit step. In divide mode the dividend sits left aligned in u_x_r and quotient
  // bits shift in from the bottom; the carry out means no borrow.
  always_comb begin
    u_busy_nxt = u_busy_r;
    u_div_nxt  = u_div_r;
    u_x_nxt    = u_x_r;
    u_y_nxt    = u_y_r;
    u_acc_nxt  = u_acc_r;
    u_cnt_nxt  = u_cnt_r;
    if (u_start) begin
      u_busy_nxt = 1'b1;
      u_div_nxt  = u_start_div;
      u_x_nxt    = u_x_init;
      u_y_nxt    = u_y_init;
      u_acc_nxt  = u_acc_init;
      u_cnt_nxt  = u_len;
    end else if (u_busy_r) begin
      if (u_div_r) begin
        u_acc_nxt = add_res[PW] ? add_res[PW-1:0] : opa;
        u_x_nxt   = {u_x_r[PW-2:0], add_res[PW]};
        u_cnt_nxt = u_cnt_r - LENW'(1);
        if (u_cnt_r == LENW'(1)) begin
          u_busy_nxt = 1'b0;
        end
      end else if (u_y_r == '0) begin
        u_busy_nxt = 1'b0;
      end else begin
        u_acc_nxt = add_res[PW-1:0];
        u_x_nxt   = u_x_r << 1;
        u_y_nxt   = u_y_r >> 1;
      end
    end
  end

  // Sequencer over the reduction rounds.
  always_comb begin
    state_nxt     = state_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    m_nxt         = m_r;
    cnt_nxt       = cnt_r;
    q_nxt         = q_r;
    sum_nxt       = sum_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    u_start       = 1'b0;
    u_start_div   = 1'b0;
    u_len         = LENW'(W);
    u_x_init      = '0;
    u_y_init      = '0;
    u_acc_init    = '0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          a_nxt   = in_tdata[W-1:0];
          b_nxt   = in_tdata[2*W-1:W];
          m_nxt   = in_tdata[3*W-1:2*W];
          cnt_nxt = CW'(in_tdata[4*W-1:3*W]) + CW'(1);
          sum_nxt = '0;
          // A zero divisor answers zero without any rounds.
          state_nxt = (in_tdata[3*W-1:2*W] == '0) ? ST_FIN : ST_CHK_A;
        end
      end
      ST_CHK_A: begin
        if (a_r >= m_r) begin
          u_start     = 1'b1;
          u_start_div = 1'b1;
          u_len       = LENW'(W);
          u_x_init    = PW'(a_r) << (PW - W);
          state_nxt   = ST_DIV_A;
        end else begin
          state_nxt = ST_CHK_B;
        end
      end
      ST_DIV_A: begin
        if (!u_busy_r) begin
          q_nxt     = u_x_r[W-1:0];
          a_nxt     = u_acc_r[W-1:0];
          u_start   = 1'b1;
          u_x_init  = PW'(cnt_r);
          u_y_init  = (cnt_r == '0) ? '0 : cnt_r - CW'(1);
          state_nxt = ST_TRI;
        end
      end
      ST_TRI: begin
        if (!u_busy_r) begin
          u_start   = 1'b1;
          u_x_init  = u_acc_r >> 1;
          u_y_init  = CW'(q_r);
          state_nxt = ST_TRIQ;
        end
      end
      ST_TRIQ: begin
        if (!u_busy_r) begin
          sum_nxt   = sum_r + fls_pkg::TOTAL_W'(u_acc_r);
          state_nxt = ST_CHK_B;
        end
      end
      ST_CHK_B: begin
        if (b_r >= m_r) begin
          u_start     = 1'b1;
          u_start_div = 1'b1;
          u_len       = LENW'(W);
          u_x_init    = PW'(b_r) << (PW - W);
          state_nxt   = ST_DIV_B;
        end else begin
          state_nxt = ST_TOP;
        end
      end
      ST_DIV_B: begin
        if (!u_busy_r) begin
          q_nxt     = u_x_r[W-1:0];
          b_nxt     = u_acc_r[W-1:0];
          u_start   = 1'b1;
          u_x_init  = PW'(cnt_r);
          u_y_init  = CW'(u_x_r[W-1:0]);
          state_nxt = ST_BQ;
        end
      end
      ST_BQ: begin
        if (!u_busy_r) begin
          sum_nxt   = sum_r + fls_pkg::TOTAL_W'(u_acc_r);
          state_nxt = ST_TOP;
        end
      end
      ST_TOP: begin
        // Largest value of the linear term: a*cnt + b, with b preloaded.
        u_start    = 1'b1;
        u_x_init   = PW'(a_r);
        u_y_init   = cnt_r;
        u_acc_init = PW'(b_r);
        state_nxt  = ST_TOP_M;
      end
      ST_TOP_M: begin
        if (!u_busy_r) begin
          if ((u_acc_r < PW'(m_r)) || (a_r == '0)) begin
            state_nxt = ST_FIN;
          end else begin
            u_start     = 1'b1;
            u_start_div = 1'b1;
            u_len       = LENW'(2 * W + 1);
            u_x_init    = u_acc_r << (W - 1);
            state_nxt   = ST_TOP_D;
          end
        end
      end
      ST_TOP_D: begin
        if (!u_busy_r) begin
          // New count is the quotient, then slope and divisor swap roles.
          cnt_nxt   = u_x_r[CW-1:0];
          b_nxt     = u_acc_r[W-1:0];
          m_nxt     = a_r;
          a_nxt     = m_r;
          state_nxt = ST_CHK_A;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = sum_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      u_busy_r    <= 1'b0;
      u_div_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      u_busy_r    <= u_busy_nxt;
      u_div_r     <= u_div_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    m_r        <= m_nxt;
    cnt_r      <= cnt_nxt;
    q_r        <= q_nxt;
    sum_r      <= sum_nxt;
    out_data_r <= out_data_nxt;
    u_x_r      <= u_x_nxt;
    u_y_r      <= u_y_nxt;
    u_acc_r    <= u_acc_nxt;
    u_cnt_r    <= u_cnt_nxt;
  end

endmodule

// ===== hdl/fls_checker.sv =====
// Port-level checks for floor_of_linear_sum, attached by the bind below.
// Depends on fls_pkg (result widths) and the top level's port list.
`timescale 1ns / 1ps

module fls_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_tvalid,
  input logic                                 in_tready,
  input logic                                 out_tvalid,
  input logic                                 out_tready,
  input logic [fls_pkg::OUT_TDATA_W-1:0]      out_tdata
);

  // A stalled result beat keeps its value.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // Once a request beat is taken the block works on it and takes no other.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while busy");

  // A new result appears only at the end of work, never while idle.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result raised without a request in progress");

  // The padding above the total is always zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[fls_pkg::OUT_TDATA_W-1:fls_pkg::TOTAL_W] == '0)
    else $error("nonzero padding in result beat");

  // Reset leaves no result pending.
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind floor_of_linear_sum fls_checker u_fls_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
